### hw/rtl/wcmrd_pkg.sv
// Shared types and constants of the windowed count-min rate detector.
// No dependencies; used by every module of the block but wcmrd_mem.
`default_nettype none
package wcmrd_pkg;

	localparam int FIELD_W  = 16;   // width of limits, spans and reported counts
	localparam int WIN_REGS = 3;    // windows that have registers (short, medium, long)
	localparam int PADDR_W  = 5;    // byte address of six 32-bit registers
	localparam int PDATA_W  = 32;
	localparam int HASH_W   = 32;

	localparam logic [2:0] REG_LIMIT_SHORT  = 3'd0;
	localparam logic [2:0] REG_LIMIT_MEDIUM = 3'd1;
	localparam logic [2:0] REG_LIMIT_LONG   = 3'd2;
	localparam logic [2:0] REG_SPAN_SHORT   = 3'd3;
	localparam logic [2:0] REG_SPAN_MEDIUM  = 3'd4;
	localparam logic [2:0] REG_SPAN_LONG    = 3'd5;

	typedef struct packed {
		logic [WIN_REGS-1:0][FIELD_W-1:0] limit;
		logic [WIN_REGS-1:0][FIELD_W-1:0] span;
	} cfg_t;

endpackage
`default_nettype wire

### hw/rtl/wcmrd_regs.sv
// Configuration register file with its APB-style port.
// Depends on wcmrd_pkg.
`default_nettype none
module wcmrd_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wcmrd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wcmrd_pkg::PDATA_W-1:0] pwdata,
	output logic      [wcmrd_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	output wcmrd_pkg::cfg_t                    cfg
);
	import wcmrd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] index;
	logic       wr_en;

	assign index  = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit[0] <= FIELD_W'(2);
			cfg_q.limit[1] <= FIELD_W'(10);
			cfg_q.limit[2] <= FIELD_W'(50);
			cfg_q.span[0]  <= FIELD_W'(10);
			cfg_q.span[1]  <= FIELD_W'(60);
			cfg_q.span[2]  <= FIELD_W'(600);
		end else if (wr_en) begin
			case (index)
				REG_LIMIT_SHORT:  cfg_q.limit[0] <= pwdata[FIELD_W-1:0];
				REG_LIMIT_MEDIUM: cfg_q.limit[1] <= pwdata[FIELD_W-1:0];
				REG_LIMIT_LONG:   cfg_q.limit[2] <= pwdata[FIELD_W-1:0];
				REG_SPAN_SHORT:   cfg_q.span[0]  <= pwdata[FIELD_W-1:0];
				REG_SPAN_MEDIUM:  cfg_q.span[1]  <= pwdata[FIELD_W-1:0];
				REG_SPAN_LONG:    cfg_q.span[2]  <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (index)
			REG_LIMIT_SHORT:  prdata = PDATA_W'(cfg_q.limit[0]);
			REG_LIMIT_MEDIUM: prdata = PDATA_W'(cfg_q.limit[1]);
			REG_LIMIT_LONG:   prdata = PDATA_W'(cfg_q.limit[2]);
			REG_SPAN_SHORT:   prdata = PDATA_W'(cfg_q.span[0]);
			REG_SPAN_MEDIUM:  prdata = PDATA_W'(cfg_q.span[1]);
			REG_SPAN_LONG:    prdata = PDATA_W'(cfg_q.span[2]);
			default:          prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/wcmrd_col.sv
// Column unit: reduces a 32-bit row hash modulo the row width.
// Depends on wcmrd_pkg. A power-of-two width is a mask, otherwise a reciprocal multiply.
`default_nettype none
module wcmrd_col #(
	parameter int ROW_WIDTH = 4096,
	parameter int COLW      = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [wcmrd_pkg::HASH_W-1:0] value,
	output logic                              done,
	output logic      [COLW-1:0]              col
);
	import wcmrd_pkg::*;

	localparam bit POW2 = (ROW_WIDTH == (1 << COLW));

	logic [COLW-1:0]   col_q;
	logic              done_q;

	assign col  = col_q;
	assign done = done_q;

	if (POW2) begin : g_mask
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end
		always_ff @(posedge clk) begin
			if (start) col_q <= value[COLW-1:0];
		end
	end else begin : g_recip
		// The quotient estimate from the truncated reciprocal is low by at most one,
		// so the remainder is below twice the width and one subtraction finishes it.
		localparam int              SH    = HASH_W + COLW;
		localparam int              PW    = 2 * HASH_W + 1;
		localparam longint unsigned RECIP = (64'd1 << SH) / 64'(ROW_WIDTH);

		logic              v_s1;
		logic              v_s2;
		logic [PW-1:0]     prod_s1;
		logic [HASH_W-1:0] val_s1;
		logic [COLW:0]     rem_s2;
		logic [HASH_W-1:0] quot;
		logic [HASH_W-1:0] rem_full;

		assign quot     = HASH_W'(prod_s1 >> SH);
		assign rem_full = val_s1 - HASH_W'(quot * HASH_W'(ROW_WIDTH));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1   <= 1'b0;
				v_s2   <= 1'b0;
				done_q <= 1'b0;
			end else begin
				v_s1   <= start;
				v_s2   <= v_s1;
				done_q <= v_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				prod_s1 <= PW'(value) * PW'(RECIP);
				val_s1  <= value;
			end
			if (v_s1) rem_s2 <= rem_full[COLW:0];
			if (v_s2) begin
				col_q <= (rem_s2 >= (COLW+1)'(ROW_WIDTH))
				         ? COLW'(rem_s2 - (COLW+1)'(ROW_WIDTH)) : rem_s2[COLW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/wcmrd_mem.sv
// Counter memory holding every sketch, one counter a word.
// No dependencies. One access a cycle, registered read data.
`default_nettype none
module wcmrd_mem #(
	parameter int DEPTH = 86016,
	parameter int AW    = 17,
	parameter int CW    = 16
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [CW-1:0] wdata,
	output logic      [CW-1:0] rdata
);
	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= wdata;
		if (rd_en) rdata_q <= mem[addr];
	end

endmodule
`default_nettype wire

### hw/rtl/windowed_count_min_rate_detector.sv
// Top level of the windowed count-min rate detector: sequencer, window timers, result register.
// Depends on wcmrd_pkg, wcmrd_regs, wcmrd_col and wcmrd_mem.
//
//  channel | handshake                 | word
//  --------+---------------------------+---------------------------------------------
//  input   | in_valid / in_stall       | cmd, hash_first, hash_second
//  output  | out_valid / out_stall     | over_/least_ short, medium, long
//  config  | psel penable pwrite pready| paddr, pwdata, prdata
//
// A key word makes NUM_ROWS passes; each pass reduces the row hash to a column (a mask
// for a power-of-two ROW_WIDTH, a reciprocal multiply otherwise) and then does a read and a
// write-back of the counter in each window, one window after another over the single memory
// port. A tick word needs no pass unless a window expires; then every expiring window is
// swept, one counter a cycle. After reset all windows are swept, and no word is accepted
// meanwhile. A stalled result sits in its output register while the next word is taken in.
`default_nettype none
module windowed_count_min_rate_detector #(
	parameter int NUM_ROWS    = 7,
	parameter int ROW_WIDTH   = 4096,
	parameter int NUM_WINDOWS = 3,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wcmrd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wcmrd_pkg::PDATA_W-1:0] pwdata,
	output logic      [wcmrd_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic [wcmrd_pkg::HASH_W-1:0]  hash_first,
	input  wire logic [wcmrd_pkg::HASH_W-1:0]  hash_second,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               over_short,
	output logic                               over_medium,
	output logic                               over_long,
	output logic      [wcmrd_pkg::FIELD_W-1:0] least_short,
	output logic      [wcmrd_pkg::FIELD_W-1:0] least_medium,
	output logic      [wcmrd_pkg::FIELD_W-1:0] least_long
);
	import wcmrd_pkg::*;

	// Only windows that have registers are ever counted or timed.
	localparam int USED_WIN = (NUM_WINDOWS < WIN_REGS) ? NUM_WINDOWS : WIN_REGS;
	localparam int COLW     = $clog2(ROW_WIDTH);
	localparam int REGION   = NUM_ROWS * ROW_WIDTH;
	localparam int DEPTH    = USED_WIN * REGION;
	localparam int AW       = $clog2(DEPTH);
	localparam int IW       = $clog2(REGION);
	localparam int WW       = (USED_WIN > 1) ? $clog2(USED_WIN) : 1;
	localparam int RW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int CW       = COUNT_BITS;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_CSTART = 7'b0000100,
		S_CWAIT  = 7'b0001000,
		S_RD     = 7'b0010000,
		S_WR     = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	cfg_t cfg;

	wcmrd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Row hash: first + r*second, wrapping at 32 bits, built by adding the stride per row.
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] stride_q;
	logic              col_done;
	logic [COLW-1:0]   col;

	wcmrd_col #(.ROW_WIDTH(ROW_WIDTH), .COLW(COLW)) u_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_CSTART),
		.value  (acc_q),
		.done   (col_done),
		.col    (col)
	);

	// Key pass position and address bases.
	logic [RW-1:0] r_q;
	logic [WW-1:0] w_q;
	logic [AW-1:0] rowbase_q;
	logic [AW-1:0] wbase_q;

	// Clearing sweep.
	logic [USED_WIN-1:0] clr_mask_q;
	logic [WW-1:0]       sw_w_q;
	logic [IW-1:0]       sw_idx_q;
	logic [AW-1:0]       swbase_q;

	logic [FIELD_W-1:0] elapsed_q [USED_WIN];
	logic [CW-1:0]      least_q   [USED_WIN];

	// Memory access.
	logic          mem_rd;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [CW-1:0] mem_wdata;
	logic [CW-1:0] mem_rdata;
	logic [CW-1:0] bumped;

	wcmrd_mem #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_mem (
		.clk   (clk),
		.rd_en (mem_rd),
		.wr_en (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Counters stick at their maximum.
	assign bumped = (mem_rdata == {CW{1'b1}}) ? mem_rdata : mem_rdata + 1'b1;

	always_comb begin
		mem_rd    = (state_q == S_RD);
		mem_we    = 1'b0;
		mem_wdata = bumped;
		mem_addr  = AW'(wbase_q + rowbase_q + AW'(col));
		if (state_q == S_CLEAR) begin
			mem_we    = clr_mask_q[sw_w_q];
			mem_wdata = '0;
			mem_addr  = AW'(swbase_q + AW'(sw_idx_q));
		end else if (state_q == S_WR) begin
			mem_we = 1'b1;
		end
	end

	// Output register.
	logic                         out_valid_q;
	logic [WIN_REGS-1:0]          over_q;
	logic [WIN_REGS-1:0][FIELD_W-1:0] least_out_q;
	logic                         out_free;
	logic [WIN_REGS-1:0]          over_d;
	logic [WIN_REGS-1:0][FIELD_W-1:0] least_d;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		for (int k = 0; k < WIN_REGS; k++) begin
			over_d[k]  = 1'b0;
			least_d[k] = '0;
		end
		for (int k = 0; k < USED_WIN; k++) begin
			least_d[k] = FIELD_W'({{FIELD_W{1'b0}}, least_q[k]});
			over_d[k]  = ({{FIELD_W{1'b0}}, least_q[k]} > {{CW{1'b0}}, cfg.limit[k]});
		end
	end

	assign in_stall = (state_q != S_IDLE);
	logic accept;
	assign accept = in_valid && !in_stall;

	// Tick handling: which windows reach their span on this second.
	logic [USED_WIN-1:0] expire;
	logic [FIELD_W-1:0]  elapsed_inc [USED_WIN];

	always_comb begin
		for (int k = 0; k < USED_WIN; k++) begin
			elapsed_inc[k] = elapsed_q[k] + 1'b1;
			expire[k]      = (elapsed_inc[k] >= cfg.span[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_mask_q  <= '1;
			sw_w_q      <= '0;
			sw_idx_q    <= '0;
			swbase_q    <= '0;
			out_valid_q <= 1'b0;
			r_q         <= '0;
			w_q         <= '0;
			for (int k = 0; k < USED_WIN; k++) elapsed_q[k] <= '0;
		end else begin
			// A finished pass loads the output register; otherwise a taken result empties it.
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					// A window that needs no clearing is skipped at once.
					if (!clr_mask_q[sw_w_q] || sw_idx_q == IW'(REGION - 1)) begin
						sw_idx_q <= '0;
						if (sw_w_q == WW'(USED_WIN - 1)) begin
							state_q <= S_IDLE;
						end else begin
							sw_w_q   <= sw_w_q + 1'b1;
							swbase_q <= AW'(swbase_q + AW'(REGION));
						end
					end else begin
						sw_idx_q <= sw_idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd) begin
							for (int k = 0; k < USED_WIN; k++) begin
								elapsed_q[k] <= expire[k] ? '0 : elapsed_inc[k];
							end
							if (expire != '0) begin
								clr_mask_q <= expire;
								sw_w_q     <= '0;
								sw_idx_q   <= '0;
								swbase_q   <= '0;
								state_q    <= S_CLEAR;
							end
						end else begin
							r_q     <= '0;
							w_q     <= '0;
							state_q <= S_CSTART;
						end
					end
				end
				S_CSTART: state_q <= S_CWAIT;
				S_CWAIT:  if (col_done) state_q <= S_RD;
				S_RD:     state_q <= S_WR;
				S_WR: begin
					if (w_q == WW'(USED_WIN - 1)) begin
						w_q <= '0;
						if (r_q == RW'(NUM_ROWS - 1)) begin
							state_q <= S_OUT;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= S_CSTART;
						end
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers of the key pass.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q     <= hash_first;
				stride_q  <= hash_second;
				rowbase_q <= '0;
				wbase_q   <= '0;
				for (int k = 0; k < USED_WIN; k++) least_q[k] <= '1;
			end
			S_WR: begin
				if (bumped < least_q[w_q]) least_q[w_q] <= bumped;
				if (w_q == WW'(USED_WIN - 1)) begin
					wbase_q   <= '0;
					rowbase_q <= AW'(rowbase_q + AW'(ROW_WIDTH));
					acc_q     <= acc_q + stride_q;
				end else begin
					wbase_q <= AW'(wbase_q + AW'(REGION));
				end
			end
			S_OUT: begin
				if (out_free) begin
					over_q      <= over_d;
					least_out_q <= least_d;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign over_short   = over_q[0];
	assign over_medium  = over_q[1];
	assign over_long    = over_q[2];
	assign least_short  = least_out_q[0];
	assign least_medium = least_out_q[1];
	assign least_long   = least_out_q[2];

`ifndef SYNTHESIS
	// A result only appears when a key pass has finished.
	a_out_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the end of a key pass");

	// The counter memory is only written during a sweep or a write-back.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_WR || state_q == S_CLEAR))
		else $error("counter memory written outside sweep or write-back");

	// No word is taken while a sweep is running.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input accepted during a clearing sweep");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench of the windowed count-min rate detector.
// Depends on wcmrd_pkg and windowed_count_min_rate_detector; nothing else.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wcmrd_pkg::*;

	localparam int ROWS = 7;
	localparam int COLS = 4096;
	localparam int WINS = 3;
	// Several times the longest quiet stretch: a sweep of all three windows.
	localparam int IDLE_LIMIT = 500000;
	// Results taken before the receiver starts its long hold-off.
	localparam int HOLD_AT = 300;

	typedef enum bit {CMD_KEY = 1'b0, CMD_TICK = 1'b1} cmd_t;

	typedef struct {
		cmd_t        cmd;
		bit [31:0]   first;
		bit [31:0]   second;
	} word_t;

	typedef struct {
		bit [WINS-1:0]   over;
		bit [15:0]       least [WINS];
	} rate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic [HASH_W-1:0] hash_first = '0, hash_second = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic over_short, over_medium, over_long;
	logic [FIELD_W-1:0] least_short, least_medium, least_long;

	windowed_count_min_rate_detector DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mirror of the block's state: the counters of all three sketches, the
	// seconds elapsed in each window and the limit and span registers.
	bit [15:0] sketch_cnt [WINS][ROWS][COLS];
	bit [15:0] elapsed [WINS];
	bit [15:0] win_limit [WINS] = '{16'd2, 16'd10, 16'd50};
	bit [15:0] win_span [WINS] = '{16'd10, 16'd60, 16'd600};

	word_t pending_q [$];
	rate_t rates_q [$];
	int errors = 0;
	int hold_left = 0;
	bit [31:0] key_pool [12][2];

	// Applies one accepted word to the mirror and queues the result it causes.
	task count_word(input word_t wd);
		rate_t res;
		bit [31:0] least32;
		bit [31:0] col;
		begin
			if (wd.cmd == CMD_TICK) begin
				for (int w = 0; w < WINS; w++) begin
					elapsed[w] = elapsed[w] + 16'd1;
					if (elapsed[w] >= win_span[w]) begin
						for (int r = 0; r < ROWS; r++)
							for (int c = 0; c < COLS; c++)
								sketch_cnt[w][r][c] = '0;
						elapsed[w] = '0;
					end
				end
			end else begin
				for (int w = 0; w < WINS; w++) begin
					least32 = 32'hFFFF_FFFF;
					for (int r = 0; r < ROWS; r++) begin
						col = (wd.first + r * wd.second) % COLS;
						if (sketch_cnt[w][r][col] != 16'hFFFF)
							sketch_cnt[w][r][col] = sketch_cnt[w][r][col] + 16'd1;
						if (sketch_cnt[w][r][col] < least32)
							least32 = sketch_cnt[w][r][col];
					end
					res.least[w] = least32[15:0];
					res.over[w] = least32 > win_limit[w];
				end
				rates_q.push_back(res);
			end
		end
	endtask

	// Driver: a new word is put up only when the port is empty or the last
	// word has just been taken, so a stalled word never changes.
	int gap_left = 0;
	always @(posedge clk) begin
		word_t wd;
		if (in_valid && !in_stall)
			count_word('{cmd_t'(cmd), hash_first, hash_second});
		if (!in_valid || !in_stall) begin
			if (gap_left > 0 || pending_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				wd = pending_q.pop_front();
				in_valid <= 1'b1;
				cmd <= wd.cmd;
				hash_first <= wd.first;
				hash_second <= wd.second;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: gap_left <= 0;
					6, 7, 8: gap_left <= $urandom_range(1, 3);
					default: gap_left <= $urandom_range(10, 40);
				endcase
			end
		end
	end

	// Monitor: checks every word taken on the output against the oldest
	// expected result, then decides the stall for the next cycle.
	int stall_left = 0;
	int taken = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		rate_t exp_r;
		bit [15:0] got [WINS];
		bit [WINS-1:0] got_over;
		if (out_valid && !out_stall) begin
			taken <= taken + 1;
			got = '{least_short, least_medium, least_long};
			got_over = {over_long, over_medium, over_short};
			if (rates_q.size() == 0) begin
				$display("%0t: result with nothing expected", $realtime);
				errors++;
			end else begin
				exp_r = rates_q.pop_front();
				for (int w = 0; w < WINS; w++) begin
					if (got_over[w] !== exp_r.over[w]) begin
						$display("%0t: over[%0d] expected %0d got %0d", $realtime, w,
							exp_r.over[w], got_over[w]);
						errors++;
					end
					if (got[w] !== exp_r.least[w]) begin
						$display("%0t: least[%0d] expected %0d got %0d", $realtime, w,
							exp_r.least[w], got[w]);
						errors++;
					end
				end
			end
		end
		if (hold_left > 0) begin
			// The long hold-off lets the block fill up and stall its input.
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held && taken >= HOLD_AT) begin
			out_stall <= 1'b1;
			held <= 1'b1;
			hold_left <= 2000;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: stall_left <= 0;
				7, 8: stall_left <= $urandom_range(1, 3);
				default: stall_left <= $urandom_range(20, 80);
			endcase
		end
	end

	// Watchdog: a stretch with no word accepted on either side ends the run.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task reg_write(input logic [2:0] idx, input bit [15:0] value);
		begin
			@(posedge clk);
			psel <= 1'b1;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= {16'h0, value};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			if (idx < WINS)
				win_limit[idx] = value;
			else
				win_span[idx - WINS] = value;
		end
	endtask

	task set_all(input bit [15:0] l0, l1, l2, s0, s1, s2);
		begin
			reg_write(REG_LIMIT_SHORT, l0);
			reg_write(REG_LIMIT_MEDIUM, l1);
			reg_write(REG_LIMIT_LONG, l2);
			reg_write(REG_SPAN_SHORT, s0);
			reg_write(REG_SPAN_MEDIUM, s1);
			reg_write(REG_SPAN_LONG, s2);
		end
	endtask

	// Mostly keys drawn from a small pool so that counts climb past the limits;
	// the rest are fresh hashes and the odd tick.
	task add_random(input int count, input int tick_pct);
		word_t wd;
		int k;
		begin
			for (int i = 0; i < count; i++) begin
				wd.cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_KEY;
				if ($urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, 11);
					wd.first = key_pool[k][0];
					wd.second = key_pool[k][1];
				end else begin
					wd.first = $urandom;
					wd.second = $urandom;
				end
				pending_q.push_back(wd);
			end
			// A phase ends on a key, so its result shows any sweep is over.
			wd.cmd = CMD_KEY;
			pending_q.push_back(wd);
		end
	endtask

	task drain;
		begin
			wait (pending_q.size() == 0 && !in_valid && rates_q.size() == 0);
			repeat (100) @(posedge clk);
		end
	endtask

	initial begin
		for (int k = 0; k < 12; k++) begin
			key_pool[k][0] = $urandom;
			key_pool[k][1] = $urandom;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: hash extremes, a key repeated past the short limit,
		// ticks with random hashes that must be ignored, a zero stride.
		pending_q.push_back('{CMD_KEY, 32'h0, 32'h0});
		pending_q.push_back('{CMD_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		pending_q.push_back('{CMD_KEY, 32'hFFFF_FFFF, 32'h0});
		pending_q.push_back('{CMD_KEY, 32'h0, 32'hFFFF_FFFF});
		pending_q.push_back('{CMD_KEY, 32'h0000_0FFF, 32'h1});
		for (int i = 0; i < 5; i++)
			pending_q.push_back('{CMD_KEY, 32'h1234_5678, 32'h9ABC_DEF1});
		pending_q.push_back('{CMD_TICK, $urandom, $urandom});
		pending_q.push_back('{CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		pending_q.push_back('{CMD_KEY, 32'h1234_5678, 32'h9ABC_DEF1});
		pending_q.push_back('{CMD_KEY, 32'hAAAA_AAAA, 32'h5555_5555});
		add_random(80, 5);
		drain();

		// Zero limits flag every key; a zero span clears on each tick.
		set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd3);
		add_random(30, 8);
		drain();

		// Top limits never flag, top spans never clear here.
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_random(90, 5);
		drain();

		// Bulk of the run with small limits; the receiver's long hold-off falls in here.
		set_all($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
			$urandom_range(20, 200), $urandom_range(20, 200), $urandom_range(20, 200));
		add_random(340, 4);
		drain();

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
